>>> design/kcl_pkg.sv
`timescale 1ns / 1ps
// kcl_pkg: shared types, register indexes and constants of the keypad code lock
// used by keypad_code_lock_core; no dependencies

package kcl_pkg;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_CODE_KEYS     = 3'd0,
		REG_CODE_LENGTH   = 3'd1,
		REG_REST_ANGLE    = 3'd2,
		REG_OPEN_ANGLE    = 3'd3,
		REG_NUDGE_ANGLE   = 3'd4,
		REG_OPEN_HOLD_MS  = 3'd5,
		REG_NUDGE_HOLD_MS = 3'd6
	} reg_index_t;

	localparam int CFG_DATA_W = 24;
	localparam int KEY_W      = 4;
	localparam int SNAP_W     = 16;
	localparam int CODE_SLOTS = 6;

	// keypad layout 1 2 3 A / 4 5 6 B / 7 8 9 C / * 0 # D
	localparam logic [KEY_W-1:0] KEY_STAR = 4'd12;
	localparam logic [KEY_W-1:0] KEY_HASH = 4'd14;

	// register reset values
	localparam logic [23:0] CODE_KEYS_RST     = 24'd34464;
	localparam logic [2:0]  CODE_LENGTH_RST   = 3'd4;
	localparam logic [7:0]  REST_ANGLE_RST    = 8'd10;
	localparam logic [7:0]  OPEN_ANGLE_RST    = 8'd180;
	localparam logic [7:0]  NUDGE_ANGLE_RST   = 8'd30;
	localparam logic [15:0] OPEN_HOLD_MS_RST  = 16'd5000;
	localparam logic [15:0] NUDGE_HOLD_MS_RST = 16'd300;

	localparam logic [11:0] DUTY_OFFSET = 12'd327;
	localparam logic [10:0] DUTY_MAX    = 11'd2047;

	// one servo command
	typedef struct packed {
		logic [7:0]  angle;
		logic [10:0] duty;
		logic [15:0] hold_ms;
		logic        locked;
		logic        matched;
		logic        last;
	} result_t;

	// pwm duty: angle*9 + 327, saturated at the 11-bit maximum
	function automatic logic [10:0] duty_of(input logic [7:0] angle);
		logic [11:0] sum;
		sum = {1'b0, angle, 3'b000} + {4'b0000, angle} + DUTY_OFFSET;
		return sum[11] ? DUTY_MAX : sum[10:0];
	endfunction

endpackage

>>> design/keypad_code_lock_core.sv
`timescale 1ns / 1ps
// keypad_code_lock_core: keypad combination lock controller, top level
// depends on kcl_pkg for types, register indexes and constants

// Each input transaction is one keypad snapshot; the lowest pressed key wins.
// The snapshot goes into an input register, from which it is decoded; then
// the entry buffer and locked flag are updated and any servo commands are
// written to a two-entry result queue. Digit, letter and '#' keys make no
// result and are taken at one per cycle. A '*' key makes one or two commands
// and is held in the input register until the result queue has room for them;
// the result queue drains one per cycle while out_ready is high.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// must only change while no transaction is in flight.

module keypad_code_lock_core #(
	parameter int CODE_MAX = 6,
	parameter int KEY_ROWS = 4,
	parameter int KEY_COLS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] key_matrix,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  servo_angle,
	output logic [10:0] servo_duty,
	output logic [15:0] hold_ms,
	output logic        now_locked,
	output logic        code_matched,
	output logic        last_command
);

	localparam int NKEYS_RAW = KEY_ROWS * KEY_COLS;
	localparam int NKEYS     = (NKEYS_RAW > kcl_pkg::SNAP_W) ? kcl_pkg::SNAP_W : NKEYS_RAW;
	localparam int CW        = $clog2(CODE_MAX + 1);
	localparam int XW        = (CW > 3) ? CW : 3;
	localparam int NCMP      = (CODE_MAX < kcl_pkg::CODE_SLOTS) ? CODE_MAX : kcl_pkg::CODE_SLOTS;

	// configuration registers
	logic [23:0] code_keys_q;
	logic [2:0]  code_length_q;
	logic [7:0]  rest_angle_q;
	logic [7:0]  open_angle_q;
	logic [7:0]  nudge_angle_q;
	logic [15:0] open_hold_ms_q;
	logic [15:0] nudge_hold_ms_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_keys_q     <= kcl_pkg::CODE_KEYS_RST;
			code_length_q   <= kcl_pkg::CODE_LENGTH_RST;
			rest_angle_q    <= kcl_pkg::REST_ANGLE_RST;
			open_angle_q    <= kcl_pkg::OPEN_ANGLE_RST;
			nudge_angle_q   <= kcl_pkg::NUDGE_ANGLE_RST;
			open_hold_ms_q  <= kcl_pkg::OPEN_HOLD_MS_RST;
			nudge_hold_ms_q <= kcl_pkg::NUDGE_HOLD_MS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				kcl_pkg::REG_CODE_KEYS:     code_keys_q     <= cfg_data;
				kcl_pkg::REG_CODE_LENGTH:   code_length_q   <= cfg_data[2:0];
				kcl_pkg::REG_REST_ANGLE:    rest_angle_q    <= cfg_data[7:0];
				kcl_pkg::REG_OPEN_ANGLE:    open_angle_q    <= cfg_data[7:0];
				kcl_pkg::REG_NUDGE_ANGLE:   nudge_angle_q   <= cfg_data[7:0];
				kcl_pkg::REG_OPEN_HOLD_MS:  open_hold_ms_q  <= cfg_data[15:0];
				kcl_pkg::REG_NUDGE_HOLD_MS: nudge_hold_ms_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// input register
	logic        valid_s1;
	logic [15:0] snap_s1;
	logic        fire;

	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			snap_s1 <= key_matrix;
		end
	end

	// lowest pressed key in row-major order
	logic                      key_found;
	logic [kcl_pkg::KEY_W-1:0] key;

	always_comb begin
		key_found = 1'b0;
		key       = '0;
		for (int i = NKEYS - 1; i >= 0; i--) begin
			if (snap_s1[i]) begin
				key_found = 1'b1;
				key       = kcl_pkg::KEY_W'(i);
			end
		end
	end

	logic is_star;
	logic is_hash;
	logic is_entry;

	assign is_star  = key_found && (key == kcl_pkg::KEY_STAR);
	assign is_hash  = key_found && (key == kcl_pkg::KEY_HASH);
	assign is_entry = key_found && !is_star && !is_hash;

	// entry buffer state
	logic [kcl_pkg::KEY_W-1:0] entry_q [CODE_MAX];
	logic [CW-1:0]             count_q;
	logic                      locked_q;

	// code compare
	logic match;

	always_comb begin
		match = (code_length_q <= 3'(kcl_pkg::CODE_SLOTS))
			&& (XW'(count_q) == XW'(code_length_q));
		for (int i = 0; i < NCMP; i++) begin
			if ((i < int'(code_length_q)) && (entry_q[i] != code_keys_q[4*i +: 4])) begin
				match = 1'b0;
			end
		end
	end

	// servo commands for a star key
	logic              locked_n;
	logic [1:0]        nres;
	kcl_pkg::result_t  r0;
	kcl_pkg::result_t  r1;

	assign locked_n = ~locked_q;

	always_comb begin
		r1.angle   = rest_angle_q;
		r1.duty    = kcl_pkg::duty_of(rest_angle_q);
		r1.hold_ms = '0;
		r1.locked  = locked_n;
		r1.matched = match;
		r1.last    = 1'b1;
		if (locked_n && match) begin
			r0   = r1;
			nres = 2'd1;
		end else begin
			r0.angle   = match ? open_angle_q : nudge_angle_q;
			r0.duty    = kcl_pkg::duty_of(r0.angle);
			r0.hold_ms = match ? open_hold_ms_q : nudge_hold_ms_q;
			r0.locked  = locked_n;
			r0.matched = match;
			r0.last    = 1'b0;
			nres       = 2'd2;
		end
	end

	// result queue occupancy and processing decision
	kcl_pkg::result_t q0_q;
	kcl_pkg::result_t q1_q;
	logic [1:0]       cnt_q;
	logic             pop;
	logic [1:0]       base;
	logic [1:0]       room;

	assign pop  = out_valid && out_ready;
	assign base = cnt_q - {1'b0, pop};
	assign room = 2'd2 - base;
	assign fire = valid_s1 && (!is_star || (nres <= room));

	// entry buffer and locked flag update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			locked_q <= 1'b1;
			for (int i = 0; i < CODE_MAX; i++) begin
				entry_q[i] <= '0;
			end
		end else if (fire) begin
			if (is_hash || is_star) begin
				count_q <= '0;
				for (int i = 0; i < CODE_MAX; i++) begin
					entry_q[i] <= '0;
				end
			end else if (is_entry && (count_q < CW'(CODE_MAX))) begin
				count_q <= count_q + CW'(1);
				for (int i = 0; i < CODE_MAX; i++) begin
					if (count_q == CW'(i)) begin
						entry_q[i] <= key;
					end
				end
			end
			if (is_star) begin
				locked_q <= locked_n;
			end
		end
	end

	// result queue next state
	kcl_pkg::result_t q0_n;
	kcl_pkg::result_t q1_n;
	logic [1:0]       cnt_n;

	always_comb begin
		q0_n  = pop ? q1_q : q0_q;
		q1_n  = q1_q;
		cnt_n = base;
		if (fire && is_star) begin
			cnt_n = base + nres;
			case (base)
				2'd0: begin
					q0_n = r0;
					q1_n = r1;
				end
				2'd1: begin
					q1_n = r0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		q0_q <= q0_n;
		q1_q <= q1_n;
	end

	// output channel
	assign out_valid    = (cnt_q != 2'd0);
	assign servo_angle  = q0_q.angle;
	assign servo_duty   = q0_q.duty;
	assign hold_ms      = q0_q.hold_ms;
	assign now_locked   = q0_q.locked;
	assign code_matched = q0_q.matched;
	assign last_command = q0_q.last;

endmodule

>>> design/kcl_checker.sv
`timescale 1ns / 1ps
// kcl_checker: port-level assertions for keypad_code_lock_core, bound to the top level
// depends on the port list of keypad_code_lock_core

module kcl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  servo_angle,
	input logic [10:0] servo_duty,
	input logic [15:0] hold_ms,
	input logic        now_locked,
	input logic        code_matched,
	input logic        last_command
);

	// stalled result transaction holds its angle, hold time and last flag
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(servo_angle)
			&& $stable(hold_ms) && $stable(last_command))
		else $error("result changed while stalled");

	// a non-final command is directly followed by a final command with the same locked and matched flags
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_command |=> out_valid && last_command
			&& (now_locked == $past(now_locked)) && (code_matched == $past(code_matched)))
		else $error("second command of a pair missing or inconsistent");

	// the final command always has a zero hold time
	a_rest: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_command |-> hold_ms == 16'd0)
		else $error("final command carries a hold time");

	// duty follows the angle
	a_duty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((servo_angle > 8'd191) ? (servo_duty == 11'd2047)
			: (servo_duty == ({3'b000, servo_angle} * 11'd9 + 11'd327))))
		else $error("duty does not match angle");

endmodule

bind keypad_code_lock_core kcl_checker u_kcl_checker (.*);
